// ===== hw/rtl/tree_map_reduce_node_unit_assert.svh =====
// Assertion macros shared by the tree map/reduce node modules.
`ifndef TREE_MAP_REDUCE_NODE_UNIT_ASSERT_SVH
`define TREE_MAP_REDUCE_NODE_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TMR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tree map/reduce node assertion failed");

// Check that a condition never holds outside reset.
`define TMR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `TMR_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== hw/rtl/tmr_pkg.sv =====
// Types, codes and defaults shared by the tree map/reduce node modules.
package tmr_pkg;

  // Default number of children per node
  localparam int unsigned TMR_FANOUT = 4;
  // Default depth of the command queue between front and back
  localparam int unsigned TMR_CMD_DEPTH = 2;

  // Reset values of the configuration registers
  localparam logic [31:0] OWN_ID_RST         = 32'd0;
  localparam logic [7:0]  ROOT_DEPTH_LIM_RST = 8'd3;

  // Root node id and depth of the root's own maps
  localparam logic [31:0] ROOT_ID        = 32'd1;
  localparam logic [7:0]  ROOT_DEPTH_NOW = 8'd1;

  // Configuration register indexes (word address bit)
  localparam logic REG_OWN_ID         = 1'b0;
  localparam logic REG_ROOT_DEPTH_LIM = 1'b1;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_MSG   = 1'b1;

  // Arriving message types
  localparam logic [7:0] MSG_MAP    = 8'd1;
  localparam logic [7:0] MSG_REDUCE = 8'd2;

  // Reduce counter saturation value
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OT_NONE   = 2'd0,
    OT_MAP    = 2'd1,
    OT_REDUCE = 2'd2
  } otype_e;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_SENT_DONE = 3'd1,
    ST_DONE      = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_HALTED    = 3'd5
  } status_e;

  // Command handed from front to back: one result, or a fan-out of maps
  typedef struct packed {
    logic        fan;
    otype_e      otype;
    logic [31:0] dest;
    logic [7:0]  depth_lim;
    logic [7:0]  depth_now;
    logic [31:0] src;
    status_e     status;
  } tmr_cmd_t;

endpackage

// ===== hw/rtl/tmr_front.sv =====
// Front end: accepts input items, updates node state and issues commands.
module tmr_front import tmr_pkg::*; #(
  parameter int unsigned Fanout = TMR_FANOUT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] own_id_i,
  input  logic [7:0]  root_depth_lim_i,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [7:0]  msg_type_i,
  input  logic [31:0] dest_id_i,
  input  logic [7:0]  depth_lim_i,
  input  logic [7:0]  depth_now_i,
  input  logic [31:0] sender_id_i,
  output logic        push_o,
  output tmr_cmd_t    cmd_o
);

  localparam logic [31:0] FanoutW = 32'(Fanout);
  localparam logic [31:0] BaseOff = 32'(Fanout - 2);
  localparam logic [7:0]  CountDone = 8'(Fanout);

  logic        halted_q, halted_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] parent_q, parent_d;
  logic [7:0]  count_inc;
  logic [31:0] child_base;
  logic [8:0]  depth_next;
  logic        push;

  // First child id; wraps modulo 2^32
  assign child_base = 32'(own_id_i * FanoutW) - BaseOff;
  assign depth_next = {1'b0, depth_now_i} + 9'd1;
  assign count_inc  = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;

  // Classify the item and build its command
  always_comb begin
    push            = 1'b0;
    halted_d        = halted_q;
    count_d         = count_q;
    parent_d        = parent_q;
    cmd_o.fan       = 1'b0;
    cmd_o.otype     = OT_NONE;
    cmd_o.dest      = '0;
    cmd_o.depth_lim = '0;
    cmd_o.depth_now = '0;
    cmd_o.src       = '0;
    cmd_o.status    = ST_HALTED;
    if (halted_q) begin
      push = 1'b1;
    end else if (kind_i == KIND_START) begin
      if (own_id_i == ROOT_ID) begin
        push            = 1'b1;
        cmd_o.fan       = 1'b1;
        cmd_o.otype     = OT_MAP;
        cmd_o.dest      = child_base;
        cmd_o.depth_lim = root_depth_lim_i;
        cmd_o.depth_now = ROOT_DEPTH_NOW;
        cmd_o.src       = own_id_i;
        cmd_o.status    = ST_SENT;
      end
    end else if (dest_id_i != own_id_i) begin
      push         = 1'b1;
      halted_d     = 1'b1;
      cmd_o.status = ST_MISMATCH;
    end else if (msg_type_i == MSG_MAP) begin
      push = 1'b1;
      if (depth_next == {1'b0, depth_lim_i}) begin
        // Leaf: reply to the sender and finish
        halted_d     = 1'b1;
        cmd_o.otype  = OT_REDUCE;
        cmd_o.dest   = sender_id_i;
        cmd_o.status = ST_SENT_DONE;
      end else begin
        parent_d        = sender_id_i;
        cmd_o.fan       = 1'b1;
        cmd_o.otype     = OT_MAP;
        cmd_o.dest      = child_base;
        cmd_o.depth_lim = depth_lim_i;
        cmd_o.depth_now = depth_next[7:0];
        cmd_o.src       = own_id_i;
        cmd_o.status    = ST_SENT;
      end
    end else if (msg_type_i == MSG_REDUCE) begin
      count_d = count_inc;
      if (count_inc == CountDone) begin
        push = 1'b1;
        if (parent_q != '0) begin
          cmd_o.otype  = OT_REDUCE;
          cmd_o.dest   = parent_q;
          cmd_o.status = ST_SENT;
        end else begin
          halted_d     = 1'b1;
          cmd_o.status = ST_DONE;
        end
      end
    end else begin
      push         = 1'b1;
      halted_d     = 1'b1;
      cmd_o.status = ST_UNKNOWN;
    end
  end

  assign push_o = accept_i & push;

  // Advance node state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      count_q  <= '0;
      parent_q <= '0;
    end else if (accept_i) begin
      halted_q <= halted_d;
      count_q  <= count_d;
      parent_q <= parent_d;
    end
  end

endmodule

// ===== hw/rtl/tmr_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module tmr_cmd_fifo import tmr_pkg::*; #(
  parameter int unsigned Depth = TMR_CMD_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tmr_cmd_t wdata_i,
  input  logic     pop_i,
  output tmr_cmd_t rdata_o,
  output logic     empty_o,
  output logic     full_o
);

`include "tree_map_reduce_node_unit_assert.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tmr_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign rdata_o = mem_q[rptr_q];

  // Step pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `TMR_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `TMR_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `TMR_ASSERT(a_ptr_match, clk_i, rst_ni, (wptr_q == rptr_q) == (empty_o || full_o))

endmodule

// ===== hw/rtl/tmr_back.sv =====
// Back end: expands queued commands into result transactions.
module tmr_back import tmr_pkg::*; #(
  parameter int unsigned Fanout = TMR_FANOUT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  tmr_cmd_t    head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_type_o,
  output logic [31:0] out_dest_o,
  output logic [7:0]  out_depth_lim_o,
  output logic [7:0]  out_depth_now_o,
  output logic [31:0] out_src_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

`include "tree_map_reduce_node_unit_assert.svh"

  localparam int unsigned IdxW = $clog2(Fanout);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Fanout - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  logic            emit, is_last;
  otype_e          type_q;
  status_e         status_q;
  logic [31:0]     dest_q, src_q;
  logic [7:0]      maxd_q, curd_q;
  logic            last_q;

  // Emit when the output register is free or being drained
  assign emit    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = !head_i.fan || (idx_q == IdxLast);
  assign pop_o   = emit && is_last;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      type_q   <= head_i.otype;
      dest_q   <= head_i.dest + 32'(idx_q);
      maxd_q   <= head_i.depth_lim;
      curd_q   <= head_i.depth_now;
      src_q    <= head_i.src;
      status_q <= head_i.status;
      last_q   <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_type_o      = type_q;
  assign out_dest_o      = dest_q;
  assign out_depth_lim_o = maxd_q;
  assign out_depth_now_o = curd_q;
  assign out_src_o       = src_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  `TMR_ASSERT(a_idx_needs_head, clk_i, rst_ni, (idx_q != '0) |-> (head_valid_i && head_i.fan))
  `TMR_ASSERT(a_emit_fills, clk_i, rst_ni, emit |=> out_valid_q)
  `TMR_ASSERT(a_pop_on_emit, clk_i, rst_ni, pop_o |-> emit)

endmodule

// ===== hw/rtl/tree_map_reduce_node_unit.sv =====
// Top level of the tree map/reduce node: configuration, front, queue and back.
//
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i/in_stall_o   kind, msg_type, dest_id, depths, sender
//  output    out        out_valid_o/out_stall_i out_type, out_dest, depths, src, status, last
//  config    in         APB psel/penable        own_id @0x0, root_depth_lim @0x4
//
// An accepted item enters the command queue; its results are then loaded from
// the queue head into the output register. A fan-out item yields Fanout results,
// one per cycle unless the output stalls; any other item yields at most one.
// The front accepts one item per cycle while the command queue has room.
// Reset clears node state, queue and output valid; no clearing pass is needed.
// Stalls on the output fill the queue, then stall the input.
module tree_map_reduce_node_unit import tmr_pkg::*; #(
  parameter int unsigned Fanout   = TMR_FANOUT,
  parameter int unsigned CmdDepth = TMR_CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  msg_type_i,
  input  logic [31:0] dest_id_i,
  input  logic [7:0]  depth_lim_i,
  input  logic [7:0]  depth_now_i,
  input  logic [31:0] sender_id_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_type_o,
  output logic [31:0] out_dest_o,
  output logic [7:0]  out_depth_lim_o,
  output logic [7:0]  out_depth_now_o,
  output logic [31:0] out_src_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic [31:0] own_id_q;
  logic [7:0]  root_depth_lim_q;
  logic        cfg_wr;
  logic        accept;
  logic        push, pop, empty, full;
  tmr_cmd_t    cmd_in, cmd_head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q         <= OWN_ID_RST;
      root_depth_lim_q <= ROOT_DEPTH_LIM_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_OWN_ID) begin
        own_id_q <= pwdata;
      end else begin
        root_depth_lim_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_OWN_ID) ? own_id_q : {24'd0, root_depth_lim_q};

  // Hold the input while the queue has no room
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  tmr_front #(
    .Fanout (Fanout)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .own_id_i         (own_id_q),
    .root_depth_lim_i (root_depth_lim_q),
    .accept_i         (accept),
    .kind_i           (kind_i),
    .msg_type_i       (msg_type_i),
    .dest_id_i        (dest_id_i),
    .depth_lim_i      (depth_lim_i),
    .depth_now_i      (depth_now_i),
    .sender_id_i      (sender_id_i),
    .push_o           (push),
    .cmd_o            (cmd_in)
  );

  tmr_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (cmd_head),
    .empty_o (empty),
    .full_o  (full)
  );

  tmr_back #(
    .Fanout (Fanout)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!empty),
    .head_i          (cmd_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_type_o      (out_type_o),
    .out_dest_o      (out_dest_o),
    .out_depth_lim_o (out_depth_lim_o),
    .out_depth_now_o (out_depth_now_o),
    .out_src_o       (out_src_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule
